>>> design/lcg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_pkg: shared types and constants of the linear congruential generator
// Holds the generator constants, the register map, the sequencer states and
// the status bundle of the remainder unit.
// ----------------------------------------------------------------------------
package lcg_pkg;

    localparam int unsigned MAX_COUNT = 64;
    localparam int unsigned CNT_W     = $clog2(MAX_COUNT + 1);

    localparam int unsigned STATE_W  = 32;
    localparam int unsigned RANGE_W  = 31;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned SUM_W    = 34;
    localparam int unsigned DIV_CNT_W = $clog2(STATE_W + 1);

    localparam logic [STATE_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [STATE_W-1:0] LCG_ADD = 32'd1013904223;

    typedef enum logic [1:0] {
        REG_SEED         = 2'd0,
        REG_MODE         = 2'd1,
        REG_RANGE_MAX    = 2'd2,
        REG_RANGE_OFFSET = 2'd3
    } lcg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_SUM,
        ST_ABS,
        ST_EMIT
    } lcg_state_t;

    typedef struct packed {
        logic               done;
        logic [RANGE_W-1:0] remainder;
    } lcg_div_stat_t;

endpackage
`default_nettype wire

>>> design/lcg_random_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_random_generator: 32-bit linear congruential random number generator
// Each input beat carries a count; the block emits that many numbers up to 64.
// ----------------------------------------------------------------------------
// Each accepted request (count 1 to 64, larger counts clamp to 64, zero gives
// nothing) produces one output beat per number, tlast on the final one. The
// state advances as state = 1664525 * state + 1013904223 mod 2^32, through a
// registered multiply and an add. In bounded mode the value is |state mod
// range_max + range_offset|; the remainder comes from a bit-serial unit. A
// zero range_max skips the remainder and uses the state itself. The input
// is not ready while a request is being worked on; the last result may still
// wait in the output register while the next request is taken. Writing the
// seed register loads the state at once; the user must write the registers
// only while the block is idle, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module lcg_random_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [6:0] count, [7] zero pad

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] value
    output logic             m_axis_tlast
);

    lcg_pkg::lcg_state_t state_reg, state_next;

    logic [lcg_pkg::STATE_W-1:0] gen_state_reg, gen_state_next;
    logic                        bounded_reg;
    logic [lcg_pkg::RANGE_W-1:0] range_max_reg;
    logic signed [31:0]          offset_reg;

    logic [lcg_pkg::CNT_W-1:0]   remain_reg, remain_next;
    logic [lcg_pkg::STATE_W-1:0] rem_val_reg, rem_val_next;
    logic [lcg_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [lcg_pkg::STATE_W-1:0] result_reg, result_next;

    logic                        out_valid_reg, out_valid_next;
    logic [lcg_pkg::STATE_W-1:0] out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;

    logic                        mac_load;
    logic [lcg_pkg::STATE_W-1:0] mac_out;
    logic                        div_start;
    lcg_pkg::lcg_div_stat_t      div_stat;

    logic [lcg_pkg::COUNT_W-1:0] req_count;
    logic [lcg_pkg::CNT_W-1:0]   req_sat;
    logic                        out_free;

    lcg_mac u_mac (
        .aclk      (aclk),
        .load      (mac_load),
        .state_in  (gen_state_reg),
        .state_out (mac_out)
    );

    lcg_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mac_out),
        .divisor  (range_max_reg),
        .status   (div_stat)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounded_reg   <= 1'b0;
            range_max_reg <= lcg_pkg::RANGE_W'(1);
            offset_reg    <= '0;
        end else if (cfg_we) begin
            unique case (lcg_pkg::lcg_reg_t'(cfg_addr))
                lcg_pkg::REG_SEED: begin
                end
                lcg_pkg::REG_MODE: begin
                    bounded_reg <= cfg_wdata[0];
                end
                lcg_pkg::REG_RANGE_MAX: begin
                    range_max_reg <= cfg_wdata[lcg_pkg::RANGE_W-1:0];
                end
                lcg_pkg::REG_RANGE_OFFSET: begin
                    offset_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign req_count = s_axis_tdata[lcg_pkg::COUNT_W-1:0];
    assign req_sat   = (req_count > lcg_pkg::COUNT_W'(lcg_pkg::MAX_COUNT))
                     ? lcg_pkg::CNT_W'(lcg_pkg::MAX_COUNT)
                     : lcg_pkg::CNT_W'(req_count);
    assign out_free  = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lcg_pkg::ST_IDLE;
            gen_state_reg <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            gen_state_reg <= gen_state_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_val_reg  <= rem_val_next;
        sum_reg      <= sum_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        gen_state_next = gen_state_reg;
        remain_next    = remain_reg;
        rem_val_next   = rem_val_reg;
        sum_next       = sum_reg;
        result_next    = result_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        s_axis_tready  = 1'b0;
        mac_load       = 1'b0;
        div_start      = 1'b0;

        // The user keeps seed writes to idle; the block does not enforce it.
        if (cfg_we && lcg_pkg::lcg_reg_t'(cfg_addr) == lcg_pkg::REG_SEED) begin
            gen_state_next = cfg_wdata;
        end

        unique case (state_reg)
            lcg_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && req_sat != '0) begin
                    remain_next = req_sat;
                    state_next  = lcg_pkg::ST_MUL;
                end
            end
            lcg_pkg::ST_MUL: begin
                mac_load   = 1'b1;
                state_next = lcg_pkg::ST_ADD;
            end
            lcg_pkg::ST_ADD: begin
                gen_state_next = mac_out;
                if (!bounded_reg) begin
                    result_next = mac_out;
                    state_next  = lcg_pkg::ST_EMIT;
                end else if (range_max_reg == '0) begin
                    // A zero divisor leaves the dividend as the remainder.
                    rem_val_next = mac_out;
                    state_next   = lcg_pkg::ST_SUM;
                end else begin
                    div_start  = 1'b1;
                    state_next = lcg_pkg::ST_DIV;
                end
            end
            lcg_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    rem_val_next = {1'b0, div_stat.remainder};
                    state_next   = lcg_pkg::ST_SUM;
                end
            end
            lcg_pkg::ST_SUM: begin
                sum_next   = {2'b00, rem_val_reg}
                           + {{2{offset_reg[31]}}, offset_reg};
                state_next = lcg_pkg::ST_ABS;
            end
            lcg_pkg::ST_ABS: begin
                if (sum_reg[lcg_pkg::SUM_W-1]) begin
                    result_next = lcg_pkg::STATE_W'(0) - sum_reg[lcg_pkg::STATE_W-1:0];
                end else begin
                    result_next = sum_reg[lcg_pkg::STATE_W-1:0];
                end
                state_next = lcg_pkg::ST_EMIT;
            end
            lcg_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    out_last_next  = (remain_reg == lcg_pkg::CNT_W'(1));
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == lcg_pkg::CNT_W'(1)) begin
                        state_next = lcg_pkg::ST_IDLE;
                    end else begin
                        state_next = lcg_pkg::ST_MUL;
                    end
                end
            end
            default: begin
                state_next = lcg_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

>>> design/lcg_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_mac: multiply-add step of the generator
// Registers the product of the state and the multiplier constant, then adds
// the increment on the way out. Both operations wrap modulo 2^32.
// ----------------------------------------------------------------------------
module lcg_mac (
    input  wire logic                          aclk,
    input  wire logic                          load,
    input  wire logic [lcg_pkg::STATE_W-1:0]   state_in,
    output logic      [lcg_pkg::STATE_W-1:0]   state_out
);

    logic [lcg_pkg::STATE_W-1:0] prod_reg;
    logic [lcg_pkg::STATE_W-1:0] prod_next;

    always_comb begin
        prod_next = state_in * lcg_pkg::LCG_MUL;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign state_out = prod_reg + lcg_pkg::LCG_ADD;

endmodule
`default_nettype wire

>>> design/lcg_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_divider: bit-serial remainder unit
// Restoring division of a 32-bit dividend by a nonzero 31-bit divisor, one
// quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module lcg_divider (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [lcg_pkg::STATE_W-1:0]   dividend,
    input  wire logic [lcg_pkg::RANGE_W-1:0]   divisor,
    output lcg_pkg::lcg_div_stat_t             status
);

    logic [lcg_pkg::STATE_W-1:0]   shift_reg;
    logic [lcg_pkg::RANGE_W-1:0]   rem_reg;
    logic [lcg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;

    logic [lcg_pkg::STATE_W-1:0]   trial;
    logic [lcg_pkg::STATE_W-1:0]   diff;
    logic [lcg_pkg::RANGE_W-1:0]   rem_next;

    always_comb begin
        trial    = {rem_reg, shift_reg[lcg_pkg::STATE_W-1]};
        diff     = trial - {1'b0, divisor};
        // The trial value stays below twice the divisor, so one subtract does.
        if (trial >= {1'b0, divisor}) begin
            rem_next = diff[lcg_pkg::RANGE_W-1:0];
        end else begin
            rem_next = trial[lcg_pkg::RANGE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= lcg_pkg::DIV_CNT_W'(lcg_pkg::STATE_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == lcg_pkg::DIV_CNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end else if (cnt_reg != '0) begin
            shift_reg <= {shift_reg[lcg_pkg::STATE_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign status.done      = done_reg;
    assign status.remainder = rem_reg;

endmodule
`default_nettype wire

>>> design/lcg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_checker: port-level checks of the random number generator
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module lcg_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,
    input  wire logic        m_axis_tlast
);

    // A stalled result beat keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // A request that asks for numbers closes the input once it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[6:0] != 7'd0 |=> !s_axis_tready)
        else $error("input ready while a request is in progress");

    // While idle, only the final beat of the previous request may still wait.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
        else $error("input ready with an unfinished request pending");

    // Reset empties the output register and leaves the input ready.
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("output not empty after reset");

endmodule

bind lcg_random_generator lcg_checker u_lcg_checker (.*);
`default_nettype wire
